>>> rtl/fmbq_pkg.sv
// Shared constants, operation and status codes, and the command/status
// structs passed between the queue controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmbq_pkg;

   localparam int DATA_W           = 32;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;
   localparam int OCC_W            = 7;
   localparam int DEFAULT_CAPACITY = 64;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_MIDDLE  = 3'd4;
   localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // The queue is split into a front half and a back half, each a ring deque.
   localparam logic HALF_FRONT = 1'b0;
   localparam logic HALF_BACK  = 1'b1;
   localparam logic END_HEAD   = 1'b0;
   localparam logic END_TAIL   = 1'b1;

   typedef struct packed {
      logic                acc_en;     // one ring access this cycle
      logic                acc_half;   // which half; also the capture source
      logic                acc_end;    // head or tail of that half
      logic                acc_push;   // write (push) or read (pop)
      logic                acc_xfer;   // write data from the other half's read port
      logic                load_word;  // latch request payload
      logic                cap_pop;    // capture read data as popped word
      logic                out_load;   // load response register
      logic [STATUS_W-1:0] status;
   } fmbq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic odd;
      logic single;
   } fmbq_stat_type;

endpackage

`default_nettype wire

>>> rtl/fmbq_if.sv
// Valid/ready channel interfaces for queue requests and responses.
// Depends on fmbq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fmbq_req_if;
   logic                             valid;
   logic                             ready;
   logic        [fmbq_pkg::OP_W-1:0]   op;
   logic signed [fmbq_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface fmbq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fmbq_pkg::DATA_W-1:0]   popped_value;
   logic        [fmbq_pkg::STATUS_W-1:0] status;
   logic        [fmbq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output popped_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input occupancy,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/fmbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/fmbq_datapath.sv
// Queue datapath: front and back half ring deques in two RAMs, their head
// and size registers, payload and response registers. Depends on fmbq_pkg, fmbq_ram.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_datapath #(
   parameter int CAPACITY = fmbq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [fmbq_pkg::DATA_W-1:0]  req_push_value,
   input  wire fmbq_pkg::fmbq_cmd_type              cmd,
   output      fmbq_pkg::fmbq_stat_type             stat,
   output      logic signed [fmbq_pkg::DATA_W-1:0]  rsp_popped_value,
   output      logic        [fmbq_pkg::STATUS_W-1:0] rsp_status,
   output      logic        [fmbq_pkg::OCC_W-1:0]   rsp_occupancy
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int DEPTH = 2 ** AW;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int DW    = fmbq_pkg::DATA_W;
   localparam int OW    = fmbq_pkg::OCC_W;

   logic [AW-1:0] fhead_ff, fhead_in, bhead_ff, bhead_in;
   logic [CW-1:0] fsize_ff, fsize_in, bsize_ff, bsize_in;
   logic [DW-1:0] word_ff, popped_ff;
   logic signed [DW-1:0]            popped_value_ff;
   logic [fmbq_pkg::STATUS_W-1:0]   status_ff;
   logic [OW-1:0]                   occupancy_ff;

   logic [AW-1:0] sel_head, tail_pos, acc_addr, new_head;
   logic [CW-1:0] sel_size, new_size, count;
   logic [CW+OW-1:0] count_wide;
   logic [DW-1:0] front_rdata, back_rdata, front_wdata, back_wdata, cap_data;
   logic          front_we, back_we, front_re, back_re;

   // ring pointer arithmetic for the selected half
   always_comb begin
      sel_head = (cmd.acc_half == fmbq_pkg::HALF_BACK) ? bhead_ff : fhead_ff;
      sel_size = (cmd.acc_half == fmbq_pkg::HALF_BACK) ? bsize_ff : fsize_ff;
      tail_pos = sel_head + AW'(sel_size);
      new_head = sel_head;
      if (cmd.acc_push) begin
         new_size = sel_size + CW'(1);
         if (cmd.acc_end == fmbq_pkg::END_HEAD) begin
            acc_addr = sel_head - AW'(1);
            new_head = acc_addr;
         end else begin
            acc_addr = tail_pos;
         end
      end else begin
         new_size = sel_size - CW'(1);
         if (cmd.acc_end == fmbq_pkg::END_HEAD) begin
            acc_addr = sel_head;
            new_head = sel_head + AW'(1);
         end else begin
            acc_addr = tail_pos - AW'(1);
         end
      end
   end

   always_comb begin
      fhead_in = fhead_ff;
      fsize_in = fsize_ff;
      bhead_in = bhead_ff;
      bsize_in = bsize_ff;
      if (cmd.acc_en) begin
         if (cmd.acc_half == fmbq_pkg::HALF_BACK) begin
            bhead_in = new_head;
            bsize_in = new_size;
         end else begin
            fhead_in = new_head;
            fsize_in = new_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fhead_ff <= '0;
         fsize_ff <= '0;
         bhead_ff <= '0;
         bsize_ff <= '0;
      end else begin
         fhead_ff <= fhead_in;
         fsize_ff <= fsize_in;
         bhead_ff <= bhead_in;
         bsize_ff <= bsize_in;
      end
   end

   // a transfer between halves writes what the other half just read out
   assign front_we    = cmd.acc_en & cmd.acc_push & (cmd.acc_half == fmbq_pkg::HALF_FRONT);
   assign back_we     = cmd.acc_en & cmd.acc_push & (cmd.acc_half == fmbq_pkg::HALF_BACK);
   assign front_re    = cmd.acc_en & ~cmd.acc_push & (cmd.acc_half == fmbq_pkg::HALF_FRONT);
   assign back_re     = cmd.acc_en & ~cmd.acc_push & (cmd.acc_half == fmbq_pkg::HALF_BACK);
   assign front_wdata = cmd.acc_xfer ? back_rdata : word_ff;
   assign back_wdata  = cmd.acc_xfer ? front_rdata : word_ff;

   fmbq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_front_ram (
      .clock (clock),
      .we    (front_we),
      .waddr (acc_addr),
      .wdata (front_wdata),
      .re    (front_re),
      .raddr (acc_addr),
      .rdata (front_rdata)
   );

   fmbq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_back_ram (
      .clock (clock),
      .we    (back_we),
      .waddr (acc_addr),
      .wdata (back_wdata),
      .re    (back_re),
      .raddr (acc_addr),
      .rdata (back_rdata)
   );

   assign cap_data   = (cmd.acc_half == fmbq_pkg::HALF_BACK) ? back_rdata : front_rdata;
   assign count      = CW'(fsize_ff + bsize_ff);
   assign count_wide = (CW + OW)'(count);

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         word_ff   <= req_push_value;
         popped_ff <= '1;
      end else if (cmd.cap_pop) begin
         popped_ff <= cap_data;
      end
      if (cmd.out_load) begin
         popped_value_ff <= popped_ff;
         status_ff       <= cmd.status;
         occupancy_ff    <= count_wide[OW-1:0];
      end
   end

   assign stat.empty  = (count == '0);
   assign stat.full   = (count == CW'(CAPACITY));
   assign stat.odd    = count[0];
   assign stat.single = (count == CW'(1));

   assign rsp_popped_value = popped_value_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occupancy_ff;

endmodule

`default_nettype wire

>>> rtl/fmbq_ctrl.sv
// Queue controller: decodes the request into a primary ring access plus an
// optional rebalance move, and sequences the datapath. Depends on fmbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [fmbq_pkg::OP_W-1:0]     req_op,
   output      logic                          req_ready,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire fmbq_pkg::fmbq_stat_type       stat,
   output      fmbq_pkg::fmbq_cmd_type        cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PRIM    = 6'b000010,
      ST_POPWAIT = 6'b000100,
      ST_BREAD   = 6'b001000,
      ST_BWRITE  = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic half_ff, end_ff, push_ff, bal_ff, src_ff, rsp_valid_ff;
   logic [fmbq_pkg::STATUS_W-1:0] status_ff;

   logic plan_run, plan_half, plan_end, plan_push, plan_bal, plan_src;
   logic [fmbq_pkg::STATUS_W-1:0] plan_status;
   logic accept, out_free;

   // Invariant: front half holds floor(count/2) entries; middle sits at the seam.
   always_comb begin
      plan_run    = 1'b0;
      plan_half   = fmbq_pkg::HALF_FRONT;
      plan_end    = fmbq_pkg::END_HEAD;
      plan_push   = 1'b0;
      plan_bal    = 1'b0;
      plan_src    = fmbq_pkg::HALF_FRONT;
      plan_status = fmbq_pkg::STATUS_DONE;
      case (req_op)
         fmbq_pkg::OP_PUSH_FRONT: begin
            plan_push = 1'b1;
            plan_bal  = ~stat.odd;
            if (stat.full) plan_status = fmbq_pkg::STATUS_FULL;
            else           plan_run    = 1'b1;
         end
         fmbq_pkg::OP_PUSH_MIDDLE: begin
            plan_push = 1'b1;
            plan_half = fmbq_pkg::HALF_BACK;
            plan_bal  = stat.odd;
            plan_src  = fmbq_pkg::HALF_BACK;
            if (stat.full) plan_status = fmbq_pkg::STATUS_FULL;
            else           plan_run    = 1'b1;
         end
         fmbq_pkg::OP_PUSH_BACK: begin
            plan_push = 1'b1;
            plan_half = fmbq_pkg::HALF_BACK;
            plan_end  = fmbq_pkg::END_TAIL;
            plan_bal  = stat.odd;
            plan_src  = fmbq_pkg::HALF_BACK;
            if (stat.full) plan_status = fmbq_pkg::STATUS_FULL;
            else           plan_run    = 1'b1;
         end
         fmbq_pkg::OP_POP_FRONT: begin
            // with one entry the front half is empty
            plan_half = stat.single ? fmbq_pkg::HALF_BACK : fmbq_pkg::HALF_FRONT;
            plan_bal  = stat.odd & ~stat.single;
            plan_src  = fmbq_pkg::HALF_BACK;
            if (stat.empty) plan_status = fmbq_pkg::STATUS_EMPTY;
            else            plan_run    = 1'b1;
         end
         fmbq_pkg::OP_POP_MIDDLE: begin
            plan_half = stat.odd ? fmbq_pkg::HALF_BACK : fmbq_pkg::HALF_FRONT;
            plan_end  = stat.odd ? fmbq_pkg::END_HEAD : fmbq_pkg::END_TAIL;
            if (stat.empty) plan_status = fmbq_pkg::STATUS_EMPTY;
            else            plan_run    = 1'b1;
         end
         fmbq_pkg::OP_POP_BACK: begin
            plan_half = fmbq_pkg::HALF_BACK;
            plan_end  = fmbq_pkg::END_TAIL;
            plan_bal  = ~stat.odd;
            plan_src  = fmbq_pkg::HALF_FRONT;
            if (stat.empty) plan_status = fmbq_pkg::STATUS_EMPTY;
            else            plan_run    = 1'b1;
         end
         default: begin
            plan_run = 1'b0;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.status    = status_ff;
      cmd.acc_half  = half_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_word = accept;
            if (accept) state_in = plan_run ? ST_PRIM : ST_DONE;
         end
         ST_PRIM: begin
            cmd.acc_en   = 1'b1;
            cmd.acc_end  = end_ff;
            cmd.acc_push = push_ff;
            if (!push_ff)    state_in = ST_POPWAIT;
            else if (bal_ff) state_in = ST_BREAD;
            else             state_in = ST_DONE;
         end
         ST_POPWAIT: begin
            cmd.cap_pop = 1'b1;
            state_in    = bal_ff ? ST_BREAD : ST_DONE;
         end
         ST_BREAD: begin
            // front half gives its tail, back half gives its head
            cmd.acc_en   = 1'b1;
            cmd.acc_half = src_ff;
            cmd.acc_end  = (src_ff == fmbq_pkg::HALF_FRONT) ? fmbq_pkg::END_TAIL
                                                           : fmbq_pkg::END_HEAD;
            state_in     = ST_BWRITE;
         end
         ST_BWRITE: begin
            cmd.acc_en   = 1'b1;
            cmd.acc_half = ~src_ff;
            cmd.acc_end  = (src_ff == fmbq_pkg::HALF_FRONT) ? fmbq_pkg::END_HEAD
                                                           : fmbq_pkg::END_TAIL;
            cmd.acc_push = 1'b1;
            cmd.acc_xfer = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            cmd.out_load = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         half_ff   <= plan_half;
         end_ff    <= plan_end;
         push_ff   <= plan_push;
         bal_ff    <= plan_bal;
         src_ff    <= plan_src;
         status_ff <= plan_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/front_middle_back_queue_top.sv
// Top level of the front/middle/back queue: controller plus datapath.
// Depends on fmbq_pkg, fmbq_if, fmbq_ctrl, fmbq_datapath.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          op, push_value
//   rsp_chan  out  valid/ready          popped_value, status, occupancy
//
// One request at a time. A rejected or unused op goes straight to done; a
// push makes one ring access; a pop makes one and captures the word from the
// registered read port of the half RAM; a rebalance reads and writes one word
// across the seam. Reset clears both halves to empty; RAM is not cleared.
// A new request is taken while a response waits; it finishes once rsp is free.
`timescale 1ns / 1ps
`default_nettype none

module front_middle_back_queue_top #(
   parameter int CAPACITY = fmbq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic   clock,
   input  wire logic   reset,
   fmbq_req_if.sink    req_chan,
   fmbq_rsp_if.source  rsp_chan
);

   fmbq_pkg::fmbq_cmd_type  cmd;
   fmbq_pkg::fmbq_stat_type stat;

   fmbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fmbq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_push_value   (req_chan.push_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_status       (rsp_chan.status),
      .rsp_occupancy    (rsp_chan.occupancy)
   );

endmodule

`default_nettype wire
